### rtl/core/utu8_pkg.sv
// utu8_pkg: shared types, constants and the unit classifier for the utf-16 to utf-8 encoder
// no dependencies; imported by every module under rtl/core
package utu8_pkg;

  localparam int UNIT_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int MAX_BYTES   = 4;
  localparam int IDX_W       = 2;
  localparam int CNT_W       = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] QMARK = 8'h3F;

  // unit classes with nothing held
  localparam logic [1:0] CLS_ONE   = 2'd0;
  localparam logic [1:0] CLS_TWO   = 2'd1;
  localparam logic [1:0] CLS_SURR  = 2'd2;
  localparam logic [1:0] CLS_THREE = 2'd3;

  // one queue entry: the bytes caused by one word and the index of the final byte
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [IDX_W-1:0]                 last_idx;
  } entry_t;

  function automatic logic [1:0] classify(input logic [UNIT_W-1:0] u);
    logic [1:0] cls;
    if (u[15:7] == 9'd0) begin
      cls = CLS_ONE;
    end else if (u[15:11] == 5'd0) begin
      cls = CLS_TWO;
    end else if (u[15:11] == 5'b11011) begin
      cls = CLS_SURR;
    end else begin
      cls = CLS_THREE;
    end
    return cls;
  endfunction

endpackage

### rtl/core/utu8_front.sv
// utu8_front: accepts code units, tracks the held high surrogate and builds byte groups
// depends on utu8_pkg
module utu8_front
  import utu8_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [UNIT_W-1:0] code_unit,
  input  logic              last_unit,
  input  logic              q_full,
  output logic              q_push,
  output entry_t            q_entry
);

  logic       pending;
  logic [9:0] held;

  logic                             accept;
  logic                             pair;
  logic                             hold_new;
  logic [MAX_BYTES-1:0][BYTE_W-1:0] pbytes;
  logic [CNT_W-1:0]                 pn;
  logic [CNT_W-1:0]                 n;
  logic [20:0]                      cp;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pair     = pending && (code_unit[15:10] == 6'b110111);
  assign cp       = {1'b0, held, code_unit[9:0]} + 21'h10000;

  // plain encoding of the incoming unit
  always_comb begin
    pbytes   = '0;
    pn       = '0;
    hold_new = 1'b0;
    unique case (classify(code_unit))
      CLS_ONE: begin
        pbytes[0] = code_unit[7:0];
        pn        = 3'd1;
      end
      CLS_TWO: begin
        pbytes[0] = {3'b110, code_unit[10:6]};
        pbytes[1] = {2'b10, code_unit[5:0]};
        pn        = 3'd2;
      end
      CLS_SURR: begin
        if (!code_unit[10] && !last_unit) begin
          hold_new = 1'b1;
        end else begin
          pbytes[0] = QMARK;
          pn        = 3'd1;
        end
      end
      default: begin
        pbytes[0] = {4'hE, code_unit[15:12]};
        pbytes[1] = {2'b10, code_unit[11:6]};
        pbytes[2] = {2'b10, code_unit[5:0]};
        pn        = 3'd3;
      end
    endcase
  end

  // combine held-surrogate handling with the plain bytes
  always_comb begin
    q_entry.bytes = '0;
    n             = '0;
    if (pair) begin
      q_entry.bytes[0] = {5'b11110, cp[20:18]};
      q_entry.bytes[1] = {2'b10, cp[17:12]};
      q_entry.bytes[2] = {2'b10, cp[11:6]};
      q_entry.bytes[3] = {2'b10, cp[5:0]};
      n                = 3'd4;
    end else if (pending) begin
      q_entry.bytes[0] = QMARK;
      q_entry.bytes[1] = pbytes[0];
      q_entry.bytes[2] = pbytes[1];
      q_entry.bytes[3] = pbytes[2];
      n                = pn + 3'd1;
    end else begin
      q_entry.bytes = pbytes;
      n             = pn;
    end
    q_entry.last_idx = IDX_W'(n - 3'd1);
  end

  // a held high surrogate with nothing held before yields no bytes
  assign q_push = accept && (n != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      held    <= '0;
    end else if (accept) begin
      if (pair) begin
        pending <= 1'b0;
        held    <= '0;
      end else begin
        pending <= hold_new;
        held    <= hold_new ? code_unit[9:0] : 10'd0;
      end
    end
  end

endmodule

### rtl/core/utu8_queue.sv
// utu8_queue: short fifo of byte groups between the front and back parts
// depends on utu8_pkg
module utu8_queue
  import utu8_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [OCC_W-1:0]   occ;

  assign empty = (occ == '0);
  assign full  = (occ == OCC_W'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        occ <= occ + 1'b1;
      end else if (pop && !push) begin
        occ <= occ - 1'b1;
      end
    end
  end

endmodule

### rtl/core/utu8_back.sv
// utu8_back: walks the head byte group and drives the registered output byte
// depends on utu8_pkg
module utu8_back
  import utu8_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  entry_t            head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] utf8_byte,
  output logic              run_end
);

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             at_end;

  assign load   = !q_empty && (!out_valid || out_ready);
  assign at_end = (idx == head.last_idx);
  assign q_pop  = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      utf8_byte <= head.bytes[idx];
      run_end   <= at_end;
    end
  end

endmodule

### rtl/core/utf16_to_utf8_encoder.sv
// utf16_to_utf8_encoder: top level of the utf-16 to utf-8 encoder
// depends on utu8_pkg, utu8_front, utu8_queue, utu8_back
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    code_unit[15:0], last_unit
//   out      source     out_valid/out_ready  utf8_byte[7:0], run_end
//
// each input word is turned into 0 to 4 bytes
// the output side delivers one byte per cycle, as long as out_ready is high and
// the queue holds a byte group; a single output byte register drives utf8_byte
// rst is synchronous and clears the held surrogate, the queue and the output
// the queue lets the front keep taking words while the output is stalled
module utf16_to_utf8_encoder
  import utu8_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [UNIT_W-1:0] code_unit,
  input  logic              last_unit,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] utf8_byte,
  output logic              run_end
);

  // front to queue
  logic   q_push;
  entry_t q_entry;
  logic   q_full;

  // queue to back
  entry_t q_head;
  logic   q_empty;
  logic   q_pop;

  // front: classify each word, pair surrogates, build its byte group
  utu8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  // decoupling queue of byte groups
  utu8_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // back: serialize the group one byte per cycle while out_ready is high, flag the final byte
  utu8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .utf8_byte (utf8_byte),
    .run_end   (run_end)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for utf16_to_utf8_encoder
// depends on utu8_pkg and the encoder rtl; sends utf-16 words and checks each utf-8 byte
module testbench;
  import utu8_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RST_CYCLES   = 11;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int TIMEOUT_NS   = 3_000_000;

  localparam logic [UNIT_W-1:0] HI_SUR_MIN = 16'hD800;
  localparam logic [UNIT_W-1:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [UNIT_W-1:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [UNIT_W-1:0] LO_SUR_MAX = 16'hDFFF;

  // one expected output byte and whether it closes the bytes of its word
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              fin;
  } utf8_exp_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [UNIT_W-1:0] code_unit = '0;
  logic              last_unit = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] utf8_byte;
  logic              run_end;

  // bytes still owed by the encoder, oldest first
  utf8_exp_t expected_utf8[$];

  // mirror of the encoder's surrogate state
  logic [9:0] held_hi    = '0;
  logic       hi_pending = 1'b0;

  int err_count      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // bumped by a test to ask the receiver for one long hold-off
  int hold_req       = 0;

  utf16_to_utf8_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .utf8_byte (utf8_byte),
    .run_end   (run_end)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // works out the bytes one accepted word causes and queues them;
  // a held high surrogate is either completed by a low one or flushed as '?'
  task automatic predict_utf8(input logic [UNIT_W-1:0] u, input logic l);
    logic [BYTE_W-1:0] seq [MAX_BYTES];
    logic [20:0]       cp;
    int                n;
    int                i;
    bit                plain;
    n     = 0;
    plain = 1'b1;
    if (hi_pending) begin
      hi_pending = 1'b0;
      if (u >= LO_SUR_MIN && u <= LO_SUR_MAX) begin
        // pair completes: four-byte sequence for the supplementary code point
        cp     = 21'h10000 + {1'b0, held_hi, u[9:0]};
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
        n      = 4;
        plain  = 1'b0;
      end else begin
        // unpaired high surrogate, then the new word goes through as usual
        seq[0] = QMARK;
        n      = 1;
      end
      held_hi = '0;
    end
    if (plain) begin
      if (u < 16'h0080) begin
        seq[n] = u[7:0];
        n      = n + 1;
      end else if (u < 16'h0800) begin
        seq[n]   = {3'b110, u[10:6]};
        seq[n+1] = {2'b10, u[5:0]};
        n        = n + 2;
      end else if (u >= HI_SUR_MIN && u <= LO_SUR_MAX) begin
        if (u <= HI_SUR_MAX && !l) begin
          // high surrogate waits for its partner, nothing comes out yet
          held_hi    = u[9:0];
          hi_pending = 1'b1;
        end else begin
          // lone low surrogate, or a high one that ends the string
          seq[n] = QMARK;
          n      = n + 1;
        end
      end else begin
        seq[n]   = {4'b1110, u[15:12]};
        seq[n+1] = {2'b10, u[11:6]};
        seq[n+2] = {2'b10, u[5:0]};
        n        = n + 3;
      end
    end
    for (i = 0; i < n; i++) begin
      expected_utf8.push_back('{b: seq[i], fin: (i == n - 1)});
    end
  endtask

  // offers one word after a random gap and holds it until the encoder takes it;
  // entered at an acceptance edge, so valid stays up when no gap is drawn
  task automatic send_word(input logic [UNIT_W-1:0] u, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_unit <= u;
    last_unit <= l;
    do @(posedge clk); while (!in_ready);
    predict_utf8(u, l);
  endtask

  function automatic logic pick_last();
    return $urandom_range(7) == 0;
  endfunction

  // one character of a string: mostly well formed, some stray surrogates and noise
  task automatic send_random_char(output int words);
    int pick;
    pick  = $urandom_range(99);
    words = 1;
    if (pick < 20) begin
      send_word(UNIT_W'($urandom_range(16'h007F)), pick_last());
    end else if (pick < 35) begin
      send_word(UNIT_W'($urandom_range(16'h07FF, 16'h0080)), pick_last());
    end else if (pick < 55) begin
      if ($urandom_range(1) == 0) begin
        send_word(UNIT_W'($urandom_range(16'hD7FF, 16'h0800)), pick_last());
      end else begin
        send_word(UNIT_W'($urandom_range(16'hFFFF, 16'hE000)), pick_last());
      end
    end else if (pick < 82) begin
      // surrogate pair; now and then the high half wrongly ends the string
      send_word(UNIT_W'($urandom_range(HI_SUR_MAX, HI_SUR_MIN)), $urandom_range(15) == 0);
      send_word(UNIT_W'($urandom_range(LO_SUR_MAX, LO_SUR_MIN)), pick_last());
      words = 2;
    end else if (pick < 90) begin
      send_word(UNIT_W'($urandom_range(LO_SUR_MAX, HI_SUR_MIN)), pick_last());
    end else begin
      send_word(UNIT_W'($urandom_range(16'hFFFF)), pick_last());
    end
  endtask

  // range edges of every byte count, pair limits and each surrogate corner
  task automatic test_directed();
    send_word(16'h0000, 1'b0);
    send_word(16'h007F, 1'b1);
    send_word(16'h0080, 1'b0);
    send_word(16'h07FF, 1'b0);
    send_word(16'h0800, 1'b0);
    send_word(16'hD7FF, 1'b0);
    send_word(16'hE000, 1'b0);
    send_word(16'hFFFF, 1'b1);
    // lowest and highest pairs, the second one ending the string
    send_word(HI_SUR_MIN, 1'b0);
    send_word(LO_SUR_MIN, 1'b0);
    send_word(HI_SUR_MAX, 1'b0);
    send_word(LO_SUR_MAX, 1'b1);
    // low surrogate with nothing held
    send_word(LO_SUR_MIN, 1'b0);
    // held high surrogate followed by plain ascii
    send_word(HI_SUR_MIN, 1'b0);
    send_word(16'h0041, 1'b0);
    // held high surrogate followed by another high one, which then pairs
    send_word(16'hD83D, 1'b0);
    send_word(16'hD83D, 1'b0);
    send_word(16'hDE00, 1'b0);
    // high surrogate that ends the string
    send_word(HI_SUR_MAX, 1'b1);
    // held high surrogate followed by a three-byte word ending the string
    send_word(HI_SUR_MIN, 1'b0);
    send_word(16'h20AC, 1'b1);
  endtask

  task automatic test_random(input int sidle, input int rstall, input int count);
    int sent;
    int w;
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    sent           = 0;
    while (sent < count) begin
      send_random_char(w);
      sent = sent + w;
    end
  endtask

  // receiver holds off for a long stretch while words keep coming,
  // so the queue fills and in_ready drops
  task automatic test_backpressure();
    int k;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = hold_req + 1;
    for (k = 0; k < 8; k++) begin
      send_word(UNIT_W'($urandom_range(16'hFFFF, 16'hE000)), 1'b0);
      send_word(UNIT_W'($urandom_range(HI_SUR_MAX, HI_SUR_MIN)), 1'b0);
      send_word(UNIT_W'($urandom_range(LO_SUR_MAX, LO_SUR_MIN)), k == 7);
    end
  endtask

  // receiver side: random stalls, plus the long hold-off when asked
  initial begin : recv_ctrl
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // every accepted byte is matched against the oldest expected one
  always @(posedge clk) begin : byte_check
    utf8_exp_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_utf8.size() == 0) begin
        $error("utf8_byte: no byte expected, got %02h", utf8_byte);
        err_count = err_count + 1;
      end else begin
        e = expected_utf8.pop_front();
        if (utf8_byte !== e.b) begin
          $error("utf8_byte: expected %02h, got %02h", e.b, utf8_byte);
          err_count = err_count + 1;
        end
        if (run_end !== e.fin) begin
          $error("run_end: expected %0b, got %0b", e.fin, run_end);
          err_count = err_count + 1;
        end
      end
    end
  end

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    // idling phases: none, sender gaps, receiver stalls, both
    test_random(0, 0, 45);
    test_random(72, 0, 45);
    test_random(0, 72, 45);
    test_random(35, 35, 45);
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_utf8.size() != 0) @(posedge clk);
    // catch any stray byte the encoder might still put out
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Regression FAIL");
    $finish;
  end

endmodule
